[rtl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, codes and control/status types of the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH     = 1024;
    localparam int MAX_BURST = 64;
    localparam int MIN_CAP   = 5;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CAP_W  = 11;
    localparam int SIZE_W = 11;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 3;
    localparam int REM_W  = $clog2(MAX_BURST + 1);
    localparam int SUM_W  = ((ADDR_W > CAP_W) ? ADDR_W : CAP_W) + 1;

    // Largest capacity the register can hold, and the value after reset.
    localparam int CAP_MAX   = (DEPTH < (2 ** CAP_W)) ? DEPTH : (2 ** CAP_W) - 1;
    localparam int CAP_RESET = (DEPTH < 1024) ? DEPTH : 1024;

    localparam int IN_FIELDS_W  = SIZE_W + BYTE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = BYTE_W + CAP_W + CAP_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [ACT_W-1:0] {
        ACT_RESET = 3'd0,
        ACT_FILL  = 3'd1,
        ACT_READ  = 3'd2,
        ACT_DROP  = 3'd3,
        ACT_BACK  = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_RD_OUT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic resp_load;
        logic rd_issue;
        logic rd_load;
    } brb_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_valid;
        logic go_read;
        logic go_resp;
        logic rd_done;
    } brb_stat_t;

endpackage

[rtl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(WORDS)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(WORDS)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/brb_ctrl.sv]
// ----------------------------------------------------------------------------
// brb_ctrl
// Sequencer of the ring buffer: clearing pass, command intake, result runs.
// ----------------------------------------------------------------------------
module brb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  brb_pkg::brb_stat_t stat,
    output brb_pkg::brb_cmd_t  cmd
);

    brb_pkg::state_t state_reg;
    brb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brb_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = brb_pkg::ST_IDLE;
                end
            end
            brb_pkg::ST_IDLE:
            begin
                if (in_valid && !stat.out_valid)
                begin
                    if (stat.go_read)
                    begin
                        state_next = brb_pkg::ST_RD_REQ;
                    end
                    else if (stat.go_resp)
                    begin
                        state_next = brb_pkg::ST_RESP;
                    end
                end
            end
            brb_pkg::ST_RESP:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
            brb_pkg::ST_RD_REQ:
            begin
                state_next = brb_pkg::ST_RD_DATA;
            end
            brb_pkg::ST_RD_DATA:
            begin
                state_next = brb_pkg::ST_RD_OUT;
            end
            brb_pkg::ST_RD_OUT:
            begin
                // Wait until the byte in the output register has been taken.
                if (!stat.out_valid)
                begin
                    state_next = stat.rd_done ? brb_pkg::ST_IDLE : brb_pkg::ST_RD_REQ;
                end
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            brb_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            brb_pkg::ST_IDLE:
            begin
                in_ready   = !stat.out_valid;
                cmd.accept = in_valid && !stat.out_valid;
            end
            brb_pkg::ST_RESP:
            begin
                cmd.resp_load = 1'b1;
            end
            brb_pkg::ST_RD_REQ:
            begin
                cmd.rd_issue = 1'b1;
            end
            brb_pkg::ST_RD_DATA:
            begin
                cmd.rd_load = 1'b1;
            end
            brb_pkg::ST_RD_OUT:
            begin
                cmd = '0;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

[rtl/brb_dp.sv]
// ----------------------------------------------------------------------------
// brb_dp
// Datapath: ring pointers, counts, fill tracking, byte store and result register.
// ----------------------------------------------------------------------------
module brb_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  brb_pkg::brb_cmd_t                  cmd,
    output brb_pkg::brb_stat_t                 stat,
    input  logic                               cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic [brb_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [brb_pkg::ACT_W-1:0]          s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [brb_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int ADDR_W     = brb_pkg::ADDR_W;
    localparam int CAP_W      = brb_pkg::CAP_W;
    localparam int SIZE_W     = brb_pkg::SIZE_W;
    localparam int BYTE_W     = brb_pkg::BYTE_W;
    localparam int REM_W      = brb_pkg::REM_W;
    localparam int SUM_W      = brb_pkg::SUM_W;
    localparam int OUT_DATA_W = brb_pkg::OUT_DATA_W;

    function automatic logic [ADDR_W-1:0] ring_fwd(
        input logic [ADDR_W-1:0] idx,
        input logic [SIZE_W-1:0] n,
        input logic [CAP_W-1:0]  cap
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(idx) + SUM_W'(n);
        if (sum >= SUM_W'(cap))
        begin
            sum = sum - SUM_W'(cap);
        end
        return sum[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] ring_bwd(
        input logic [ADDR_W-1:0] idx,
        input logic [SIZE_W-1:0] n,
        input logic [CAP_W-1:0]  cap
    );
        logic [SUM_W-1:0] res;
        if (SUM_W'(idx) >= SUM_W'(n))
        begin
            res = SUM_W'(idx) - SUM_W'(n);
        end
        else
        begin
            res = SUM_W'(idx) + SUM_W'(cap) - SUM_W'(n);
        end
        return res[ADDR_W-1:0];
    endfunction

    // Ring state
    logic [CAP_W-1:0]  cap_reg;
    logic [ADDR_W-1:0] ri_reg, ri_next;
    logic [ADDR_W-1:0] wi_reg, wi_next;
    logic [CAP_W-1:0]  used_reg, used_next;
    logic              fill_active_reg, fill_active_next;
    logic              fill_failed_reg, fill_failed_next;
    logic [REM_W-1:0]  fill_rem_reg, fill_rem_next;
    logic              status_reg, status_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [REM_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Result register
    logic              out_valid_reg;
    logic              out_status_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic [CAP_W-1:0]  out_used_reg;
    logic [CAP_W-1:0]  out_free_reg;

    // Input fields
    brb_pkg::action_t  act;
    logic [SIZE_W-1:0] size;
    logic [BYTE_W-1:0] in_byte;

    logic [CAP_W-1:0]  free_w;
    logic [CAP_W-1:0]  cap_clamp;
    logic              size_zero, size_gt_used, size_gt_free, size_gt_max;
    logic              fill_wr;
    logic              go_read, go_resp;
    logic              f_failed;
    logic [REM_W-1:0]  f_rem;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign act     = brb_pkg::action_t'(s_tuser);
    assign size    = s_tdata[SIZE_W-1:0];
    assign in_byte = s_tdata[SIZE_W+BYTE_W-1:SIZE_W];

    assign free_w       = cap_reg - used_reg;
    assign size_zero    = (size == '0);
    assign size_gt_used = (size > used_reg);
    assign size_gt_free = (size > free_w);
    assign size_gt_max  = (size > SIZE_W'(brb_pkg::MAX_BURST));

    always_comb
    begin
        if (cfg_wdata < CAP_W'(brb_pkg::MIN_CAP))
        begin
            cap_clamp = CAP_W'(brb_pkg::MIN_CAP);
        end
        else if (cfg_wdata > CAP_W'(brb_pkg::CAP_MAX))
        begin
            cap_clamp = CAP_W'(brb_pkg::CAP_MAX);
        end
        else
        begin
            cap_clamp = cfg_wdata;
        end
    end

    // Decode of one accepted word and the state it leaves.
    always_comb
    begin
        ri_next          = ri_reg;
        wi_next          = wi_reg;
        used_next        = used_reg;
        fill_active_next = 1'b0;
        fill_failed_next = 1'b0;
        fill_rem_next    = '0;
        status_next      = 1'b0;
        rd_addr_next     = rd_addr_reg;
        rd_cnt_next      = rd_cnt_reg;
        fill_wr          = 1'b0;
        go_read          = 1'b0;
        go_resp          = 1'b1;
        f_failed         = 1'b0;
        f_rem            = '0;
        unique case (act)
            brb_pkg::ACT_FILL:
            begin
                // The first word of a burst checks its size; later words reuse it.
                if (fill_active_reg)
                begin
                    f_failed = fill_failed_reg;
                    f_rem    = fill_rem_reg;
                end
                else
                begin
                    f_failed = size_zero || size_gt_free || size_gt_max;
                    f_rem    = f_failed ? '0 : size[REM_W-1:0];
                end
                if (!f_failed)
                begin
                    if (f_rem == '0)
                    begin
                        f_failed = 1'b1;
                    end
                    else
                    begin
                        fill_wr   = 1'b1;
                        wi_next   = ring_fwd(wi_reg, SIZE_W'(1), cap_reg);
                        used_next = used_reg + CAP_W'(1);
                        f_rem     = f_rem - REM_W'(1);
                    end
                end
                if (s_tlast)
                begin
                    status_next = f_failed || (f_rem != '0);
                end
                else
                begin
                    go_resp          = 1'b0;
                    fill_active_next = 1'b1;
                    fill_failed_next = f_failed;
                    fill_rem_next    = f_rem;
                end
            end
            brb_pkg::ACT_RESET:
            begin
                ri_next   = '0;
                wi_next   = '0;
                used_next = '0;
            end
            brb_pkg::ACT_READ:
            begin
                if (size_zero || size_gt_used || size_gt_max)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    go_read      = 1'b1;
                    go_resp      = 1'b0;
                    rd_addr_next = ri_reg;
                    rd_cnt_next  = size[REM_W-1:0];
                    ri_next      = ring_fwd(ri_reg, size, cap_reg);
                    used_next    = used_reg - size;
                end
            end
            brb_pkg::ACT_DROP:
            begin
                if (size_zero || size_gt_used)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    ri_next   = ring_fwd(ri_reg, size, cap_reg);
                    used_next = used_reg - size;
                end
            end
            brb_pkg::ACT_BACK:
            begin
                if (size_zero || size_gt_free)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    ri_next   = ring_bwd(ri_reg, size, cap_reg);
                    used_next = used_reg + size;
                end
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg         <= CAP_W'(brb_pkg::CAP_RESET);
            ri_reg          <= '0;
            wi_reg          <= '0;
            used_reg        <= '0;
            fill_active_reg <= 1'b0;
            fill_failed_reg <= 1'b0;
            fill_rem_reg    <= '0;
            rd_cnt_reg      <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg         <= cap_clamp;
                ri_reg          <= '0;
                wi_reg          <= '0;
                used_reg        <= '0;
                fill_active_reg <= 1'b0;
                fill_failed_reg <= 1'b0;
                fill_rem_reg    <= '0;
            end
            else if (cmd.accept)
            begin
                ri_reg          <= ri_next;
                wi_reg          <= wi_next;
                used_reg        <= used_next;
                fill_active_reg <= fill_active_next;
                fill_failed_reg <= fill_failed_next;
                fill_rem_reg    <= fill_rem_next;
            end

            if (cmd.accept)
            begin
                rd_cnt_reg <= rd_cnt_next;
            end
            else if (cmd.rd_load)
            begin
                rd_cnt_reg <= rd_cnt_reg - REM_W'(1);
            end

            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            if (cmd.resp_load || cmd.rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg  <= status_next;
            rd_addr_reg <= rd_addr_next;
        end
        else if (cmd.rd_load)
        begin
            rd_addr_reg <= ring_fwd(rd_addr_reg, SIZE_W'(1), cap_reg);
        end

        if (cmd.resp_load)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_used_reg   <= used_reg;
            out_free_reg   <= free_w;
        end
        else if (cmd.rd_load)
        begin
            out_status_reg <= 1'b0;
            out_data_reg   <= ram_rdata;
            out_last_reg   <= (rd_cnt_reg == REM_W'(1));
            out_used_reg   <= used_reg;
            out_free_reg   <= free_w;
        end
    end

    // The clearing pass after reset shares the write port with fill words.
    assign ram_we    = cmd.clear_step || (cmd.accept && fill_wr);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : wi_reg;
    assign ram_wdata = cmd.clear_step ? '0 : in_byte;

    brb_ram #(
        .WIDTH (BYTE_W),
        .WORDS (brb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_issue),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    assign stat.clear_last = (clr_cnt_reg == ADDR_W'(brb_pkg::DEPTH - 1));
    assign stat.out_valid  = out_valid_reg;
    assign stat.go_read    = go_read;
    assign stat.go_resp    = go_resp;
    assign stat.rd_done    = (rd_cnt_reg == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_DATA_W'({out_free_reg, out_used_reg, out_data_reg});

endmodule

[rtl/byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte ring buffer with a programmable capacity and fill/read/drop/back commands.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-byte store to zero, one byte per
// cycle, with s_tready low until the sweep ends; capacity writes are taken
// then. A fill word that ends no burst leaves the block ready, so a burst
// streams at one byte per cycle while no result waits on the master side. A
// word giving one result (reset, drop, back, the last fill word, a rejected
// request) passes intake, loading of the result register and hand-off on the
// master side. A read run moves bytes one at a time through the read request
// to the byte store, the registered read data and the single result register,
// each new request held until that register is empty. Not enforced by the block:
// the user writes capacity through cfg_we/cfg_wdata only while no word is pending.
module byte_ring_buffer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brb_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // burst_size [10:0], data_byte [18:11], zero fill above
    input  logic [brb_pkg::IN_DATA_W-1:0]      s_tdata,
    // action [2:0]
    input  logic [brb_pkg::ACT_W-1:0]          s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // data_out [7:0], used_bytes [18:8], free_bytes [29:19], zero fill above
    output logic [brb_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status [0]
    output logic                               m_tuser,
    output logic                               m_tlast
);

    brb_pkg::brb_cmd_t  cmd;
    brb_pkg::brb_stat_t stat;

    brb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brb_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring buffer. Command words (reset, fill,
// read, drop, back and undefined codes) go in on the slave stream, and each
// accepted word is run through a scoreboard that mirrors the ring. Every word
// on the master stream is compared with the oldest predicted word. The run
// steps through several capacities and idle patterns, and holds the receiver
// off at least once long enough for the block to back up its input.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH      = brb_pkg::DEPTH;
    localparam int MAX_BURST  = brb_pkg::MAX_BURST;
    localparam int MIN_CAP    = brb_pkg::MIN_CAP;
    localparam int CAP_RESET  = brb_pkg::CAP_RESET;
    localparam int CAP_W      = brb_pkg::CAP_W;
    localparam int SIZE_W     = brb_pkg::SIZE_W;
    localparam int BYTE_W     = brb_pkg::BYTE_W;
    localparam int ACT_W      = brb_pkg::ACT_W;
    localparam int IN_DATA_W  = brb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = brb_pkg::OUT_DATA_W;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 24;
    localparam int END_CYCLES     = 60;
    localparam int PHASE_WORDS    = 10;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int SIZE_ALL       = (1 << SIZE_W) - 1;

    localparam logic [ACT_W-1:0] ACT_UNDEF_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNDEF_LAST  = 3'd7;

    typedef struct {
        logic              status;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CAP_W-1:0]  used;
        logic [CAP_W-1:0]  free;
    } ring_word_t;

    // Mirror of the ring: predicts the result words of every accepted command.
    class ring_scoreboard;
        logic [BYTE_W-1:0] ring_mem [DEPTH];
        int unsigned       cap;
        int unsigned       rd_ptr;
        int unsigned       wr_ptr;
        int unsigned       held_bytes;
        bit                burst_open;
        bit                burst_bad;
        int unsigned       burst_left;
        ring_word_t        expected_words [$];
        int unsigned       errors;
        int unsigned       words_checked;

        function new();
            foreach (ring_mem[i])
                ring_mem[i] = '0;
            cap = CAP_RESET;
            errors = 0;
            words_checked = 0;
            empty_ring();
        endfunction

        function void empty_ring();
            rd_ptr = 0;
            wr_ptr = 0;
            held_bytes = 0;
            burst_open = 0;
            burst_bad = 0;
            burst_left = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] value);
            if (value < MIN_CAP)
                cap = MIN_CAP;
            else if (value > DEPTH)
                cap = DEPTH;
            else
                cap = value;
            empty_ring();
        endfunction

        function int unsigned room_bytes();
            return (held_bytes <= cap) ? cap - held_bytes : 0;
        endfunction

        function int unsigned step_fwd(int unsigned idx, int unsigned n);
            int unsigned r;
            r = idx + n;
            while (r >= cap)
                r -= cap;
            return r;
        endfunction

        function int unsigned step_back(int unsigned idx, int unsigned n);
            while (n > cap)
                n -= cap;
            return (idx >= n) ? idx - n : idx + cap - n;
        endfunction

        function void push_word(logic st, logic [BYTE_W-1:0] d, logic l);
            ring_word_t w;
            w.status = st;
            w.data = d;
            w.last = l;
            w.used = CAP_W'(held_bytes);
            w.free = CAP_W'(room_bytes());
            expected_words.push_back(w);
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [SIZE_W-1:0] size,
                                   logic [BYTE_W-1:0] b, logic lst);
            bit          bad;
            int unsigned start;
            if (act == brb_pkg::ACT_FILL)
            begin
                // The size of a burst is taken from its first word only.
                if (!burst_open)
                begin
                    burst_open = 1;
                    burst_bad = (size == 0) || (size > room_bytes()) || (size > MAX_BURST);
                    burst_left = burst_bad ? 0 : size;
                end
                if (!burst_bad)
                begin
                    if (burst_left == 0)
                        burst_bad = 1;
                    else
                    begin
                        ring_mem[wr_ptr] = b;
                        wr_ptr = step_fwd(wr_ptr, 1);
                        held_bytes++;
                        burst_left--;
                    end
                end
                if (lst)
                begin
                    bad = burst_bad || (burst_left != 0);
                    burst_open = 0;
                    burst_bad = 0;
                    burst_left = 0;
                    push_word(bad, '0, 1'b1);
                end
                return;
            end
            // Any other command silently closes an open burst.
            burst_open = 0;
            burst_bad = 0;
            burst_left = 0;
            case (act)
                brb_pkg::ACT_RESET:
                begin
                    empty_ring();
                    push_word(1'b0, '0, 1'b1);
                end
                brb_pkg::ACT_READ:
                begin
                    if (size == 0 || size > held_bytes || size > MAX_BURST)
                        push_word(1'b1, '0, 1'b1);
                    else
                    begin
                        start = rd_ptr;
                        rd_ptr = step_fwd(rd_ptr, size);
                        held_bytes -= size;
                        for (int unsigned i = 0; i < size; i++)
                            push_word(1'b0, ring_mem[step_fwd(start, i)], i + 1 == size);
                    end
                end
                brb_pkg::ACT_DROP:
                begin
                    bad = (size == 0) || (size > held_bytes);
                    if (!bad)
                    begin
                        rd_ptr = step_fwd(rd_ptr, size);
                        held_bytes -= size;
                    end
                    push_word(bad, '0, 1'b1);
                end
                brb_pkg::ACT_BACK:
                begin
                    bad = (size == 0) || (size > room_bytes());
                    if (!bad)
                    begin
                        rd_ptr = step_back(rd_ptr, size);
                        held_bytes += size;
                    end
                    push_word(bad, '0, 1'b1);
                end
                default:
                    push_word(1'b1, '0, 1'b1);
            endcase
        endfunction

        function void check_word(logic st, logic [BYTE_W-1:0] d, logic l,
                                 logic [CAP_W-1:0] u, logic [CAP_W-1:0] f);
            ring_word_t w;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result word: status %0d data %02h last %0d %s",
                             st, d, l, $sformatf("used %0d free %0d", u, f));
                return;
            end
            w = expected_words.pop_front();
            words_checked++;
            if (w.status !== st || w.data !== d || w.last !== l || w.used !== u
                || w.free !== f)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("result %0d mismatch:", words_checked);
                    $display("  expected status %0d data %02h last %0d used %0d free %0d",
                             w.status, w.data, w.last, w.used, w.free);
                    $display("  got      status %0d data %02h last %0d used %0d free %0d",
                             st, d, l, u, f);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CAP_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    ring_scoreboard sb;
    int unsigned    tx_idle_pct;
    int unsigned    rx_stall_pct;
    int unsigned    holds_asked;
    int unsigned    words_sent;
    int unsigned    quiet_cycles;
    int unsigned    settings_used;

    byte_ring_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
        clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Both handshakes are sampled here, before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (s_tvalid === 1'b1 && s_tready === 1'b1)
                sb.note_command(s_tuser, s_tdata[SIZE_W-1:0],
                                s_tdata[SIZE_W+BYTE_W-1:SIZE_W], s_tlast);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_word(m_tuser, m_tdata[BYTE_W-1:0], m_tlast,
                              m_tdata[BYTE_W+CAP_W-1:BYTE_W],
                              m_tdata[BYTE_W+2*CAP_W-1:BYTE_W+CAP_W]);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    initial
    begin
        int unsigned holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_word(input logic [ACT_W-1:0] act, input logic [SIZE_W-1:0] size,
                             input logic [BYTE_W-1:0] b, input logic lst);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W - SIZE_W - BYTE_W){1'b0}}, b, size};
        s_tuser <= act;
        s_tlast <= lst;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_cmd(input logic [ACT_W-1:0] act, input logic [SIZE_W-1:0] size);
        send_word(act, size, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Sends count fill words; the first carries the declared size.
    task automatic fill_burst(input int unsigned declared, input int unsigned count,
                              input bit close);
        for (int unsigned i = 0; i < count; i++)
            send_word(brb_pkg::ACT_FILL,
                      (i == 0) ? SIZE_W'(declared) : SIZE_W'($urandom_range(SIZE_ALL)),
                      BYTE_W'($urandom_range(255)), close && (i == count - 1));
    endtask

    function automatic int unsigned off_size(input int unsigned limit);
        case ($urandom_range(3))
            0: return 0;
            1: return limit + 1;
            2: return MAX_BURST + 1;
            default: return $urandom_range(SIZE_ALL);
        endcase
    endfunction

    task automatic random_op();
        int unsigned pick;
        int unsigned variant;
        int unsigned room;
        int unsigned held;
        int unsigned lim;
        int unsigned n;
        room = sb.room_bytes();
        held = sb.held_bytes;
        pick = $urandom_range(99);
        variant = $urandom_range(9);
        if (pick < 40)
        begin
            lim = (room > MAX_BURST) ? MAX_BURST : room;
            n = (lim == 0) ? 1 : $urandom_range(lim, 1);
            if (variant == 0)
                fill_burst(n, n + $urandom_range(3, 1), 1'b1);
            else if (variant == 1 && n > 1)
                fill_burst(n, $urandom_range(n - 1, 1), 1'b1);
            else if (variant == 2)
                fill_burst(n, $urandom_range(n, 1), 1'b0);
            else
                fill_burst(n, n, 1'b1);
        end
        else if (pick < 65)
        begin
            lim = (held > MAX_BURST) ? MAX_BURST : held;
            if (lim == 0 || variant == 0)
                send_cmd(brb_pkg::ACT_READ, SIZE_W'(off_size(lim)));
            else
                send_cmd(brb_pkg::ACT_READ, SIZE_W'($urandom_range(lim, 1)));
        end
        else if (pick < 75)
        begin
            if (held == 0 || variant == 0)
                send_cmd(brb_pkg::ACT_DROP, SIZE_W'(off_size(held)));
            else
                send_cmd(brb_pkg::ACT_DROP, SIZE_W'($urandom_range(held, 1)));
        end
        else if (pick < 85)
        begin
            if (room == 0 || variant == 0)
                send_cmd(brb_pkg::ACT_BACK, SIZE_W'(off_size(room)));
            else
                send_cmd(brb_pkg::ACT_BACK, SIZE_W'($urandom_range(room, 1)));
        end
        else if (pick < 89)
            send_cmd(brb_pkg::ACT_RESET, SIZE_W'($urandom_range(SIZE_ALL)));
        else if (pick < 93)
            send_cmd(ACT_W'($urandom_range(ACT_UNDEF_LAST, ACT_UNDEF_FIRST)),
                     SIZE_W'($urandom_range(SIZE_ALL)));
        else
            send_word(ACT_W'($urandom_range(ACT_UNDEF_LAST)), SIZE_W'($urandom_range(SIZE_ALL)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // The block may still be busy with a fill word that gives no result.
    // Waiting on the clock first lets the last accepted word reach the scoreboard.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_capacity(value);
        settings_used++;
    endtask

    int unsigned phase_cap [NUM_PHASES] = '{5, 2047, 37, 1024, 6, 0, 1025, 0};
    int unsigned phase_tx  [NUM_PHASES] = '{0, 84, 0, 28, 0, 84, 0, 28};
    int unsigned phase_rx  [NUM_PHASES] = '{0, 0, 84, 28, 0, 0, 84, 28};

    initial
    begin
        int unsigned target;
        sb = new();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        words_sent = 0;
        settings_used = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= brb_pkg::ACT_RESET;
        s_tlast <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity.
        send_cmd(brb_pkg::ACT_RESET, SIZE_W'(0));
        send_cmd(brb_pkg::ACT_READ, SIZE_W'(1));
        fill_burst(0, 1, 1'b1);
        send_word(brb_pkg::ACT_FILL, SIZE_W'(4), 8'h00, 1'b0);
        send_word(brb_pkg::ACT_FILL, SIZE_W'(SIZE_ALL), 8'hFF, 1'b0);
        send_word(brb_pkg::ACT_FILL, SIZE_W'(0), 8'hA5, 1'b0);
        send_word(brb_pkg::ACT_FILL, SIZE_W'(0), 8'h5A, 1'b1);
        // Rewind over never-written bytes, then wrap a whole-ring drop.
        send_cmd(brb_pkg::ACT_BACK, SIZE_W'(1020));
        send_cmd(brb_pkg::ACT_DROP, SIZE_W'(1024));
        send_cmd(brb_pkg::ACT_BACK, SIZE_W'(4));
        send_cmd(brb_pkg::ACT_READ, SIZE_W'(4));
        send_cmd(brb_pkg::ACT_READ, SIZE_W'(MAX_BURST + 1));
        send_cmd(brb_pkg::ACT_DROP, SIZE_W'(0));
        send_cmd(brb_pkg::ACT_BACK, SIZE_W'(SIZE_ALL));
        fill_burst(2, 4, 1'b1);
        fill_burst(5, 2, 1'b1);
        fill_burst(3, 1, 1'b0);
        send_cmd(brb_pkg::ACT_DROP, SIZE_W'(1));
        fill_burst(MAX_BURST + 1, 1, 1'b1);
        send_cmd(ACT_UNDEF_FIRST, SIZE_W'(3));

        phase_cap[NUM_PHASES - 1] = $urandom_range(DEPTH, MIN_CAP);
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_capacity(CAP_W'(phase_cap[p]));
            tx_idle_pct = phase_tx[p];
            rx_stall_pct = phase_rx[p];
            if (phase_cap[p] == DEPTH)
            begin
                // Load part of the ring, then keep offering words while the
                // receiver holds off.
                repeat (2) fill_burst(MAX_BURST, MAX_BURST, 1'b1);
                holds_asked++;
                send_cmd(brb_pkg::ACT_READ, SIZE_W'(MAX_BURST));
                send_cmd(brb_pkg::ACT_READ, SIZE_W'(30));
                fill_burst(10, 10, 1'b1);
                send_cmd(brb_pkg::ACT_DROP, SIZE_W'(5));
                send_cmd(brb_pkg::ACT_BACK, SIZE_W'(7));
            end
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                random_op();
        end

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.expected_words.size() != 0)
        begin
            sb.errors++;
            $display("%0d predicted result words never arrived", sb.expected_words.size());
        end
        $display("Sent %0d command words over %0d capacity settings and four idle patterns;",
                 words_sent, settings_used + 1);
        $display("checked %0d result words, %0d failures.", sb.words_checked, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/brb_pkg.sv
rtl/brb_ram.sv
rtl/brb_ctrl.sv
rtl/brb_dp.sv
rtl/byte_ring_buffer.sv
tb/testbench.sv
